FILE: hdl/assert_macros.svh
// Assertion macros used by the wheel speed RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BWS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define BWS_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define BWS_ASSERT(label, clk, rst, prop)
`define BWS_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hdl/bws_pkg.sv
// Shared types, widths, register codes and weight table of the wheel speed block.
// No dependencies.
package bws_pkg;

  localparam int SensorCount = 8;
  localparam int ReadingW    = 12;
  localparam int SpeedW      = 12;
  localparam int ProductW    = 24;
  localparam int AccW        = 29;
  localparam int FloorW      = AccW - 8;
  localparam int DiffW       = FloorW + 1;
  localparam int OffsetW     = 15;
  localparam int OffsetLimit = 16384;
  localparam int QueueDepth  = 2;
  localparam int AddrW       = 5;
  localparam int DataW       = 32;
  localparam int RegIdxW     = 3;

  localparam logic [RegIdxW-1:0] RegSensorThr = 3'd0;
  localparam logic [RegIdxW-1:0] RegBrakeThr  = 3'd1;
  localparam logic [RegIdxW-1:0] RegBaseSpeed = 3'd2;
  localparam logic [RegIdxW-1:0] RegBrakeStep = 3'd3;
  localparam logic [RegIdxW-1:0] RegMaxSpeed  = 3'd4;

  // Sensors whose weight is negative on each wheel
  localparam logic [SensorCount-1:0] LeftNeg  = 8'b0000_0111;
  localparam logic [SensorCount-1:0] RightNeg = 8'b1110_0000;

  typedef struct packed {
    logic [11:0] sensor_threshold;
    logic [11:0] brake_threshold;
    logic [10:0] base_speed;
    logic [12:0] brake_step;
    logic [10:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic [ReadingW-1:0] prox_0;
    logic [ReadingW-1:0] prox_1;
    logic [ReadingW-1:0] prox_2;
    logic [ReadingW-1:0] prox_3;
    logic [ReadingW-1:0] prox_4;
    logic [ReadingW-1:0] prox_5;
    logic [ReadingW-1:0] prox_6;
    logic [ReadingW-1:0] prox_7;
  } in_t;

  typedef struct packed {
    logic [SensorCount-1:0][ReadingW-1:0] reading;
    logic                                 brake;
  } mid_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] left_cmd;
    logic signed [SpeedW-1:0] right_cmd;
    logic                     brake_active;
  } res_t;

  // Q4.8 weight magnitudes
  function automatic logic [ReadingW-1:0] weight_mag(input logic [2:0] idx);
    logic [ReadingW-1:0] mag;
    unique case (idx)
      3'd0, 3'd7: mag = 12'd2294;
      3'd1, 3'd6: mag = 12'd3277;
      3'd2, 3'd5: mag = 12'd1966;
      default:    mag = 12'd1638;
    endcase
    return mag;
  endfunction

endpackage

FILE: hdl/bws_fifo.sv
// Small register queue used between front and back and at the result side.
// Depends on nothing; width and depth come from parameters.
module bws_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/bws_front.sv
// Front end: thresholds the readings of one frame and flags the brake condition.
// Depends on bws_pkg.
module bws_front (
  input  bws_pkg::cfg_t cfg,
  input  bws_pkg::in_t  frame,
  output bws_pkg::mid_t item
);

  logic [bws_pkg::SensorCount-1:0][bws_pkg::ReadingW-1:0] raw;

  assign raw = {frame.prox_7, frame.prox_6, frame.prox_5, frame.prox_4,
                frame.prox_3, frame.prox_2, frame.prox_1, frame.prox_0};

  always_comb begin
    for (int i = 0; i < bws_pkg::SensorCount; i++) begin
      item.reading[i] = (raw[i] > cfg.sensor_threshold) ? raw[i] : '0;
    end
    item.brake = (frame.prox_0 > cfg.brake_threshold) &&
                 (frame.prox_7 > cfg.brake_threshold);
  end

endmodule

FILE: hdl/bws_back.sv
// Back end: weighted sums, brake offset and clamp, in a stalling pipeline.
// Depends on bws_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bws_back (
  input  logic          clk,
  input  logic          rst,
  input  bws_pkg::cfg_t cfg,
  input  logic          mid_empty,
  input  bws_pkg::mid_t mid_data,
  output logic          mid_pop,
  input  logic          out_full,
  input  logic          out_rd,
  output logic          out_wr,
  output bws_pkg::res_t out_data
);

  localparam int N = bws_pkg::SensorCount;

  logic adv;
  logic out_ok;

  logic                               v1;
  logic [N-1:0][bws_pkg::ProductW-1:0] prod;
  logic                               brake1;

  logic                                v2;
  logic signed [bws_pkg::FloorW-1:0]   fl_l;
  logic signed [bws_pkg::FloorW-1:0]   fl_r;
  logic                                brake2;
  logic [bws_pkg::OffsetW-1:0]         offset;
  logic [bws_pkg::OffsetW-1:0]         offset_next;

  logic [N-1:0][bws_pkg::ProductW-1:0] prod_next;
  logic signed [bws_pkg::AccW-1:0]     acc_l;
  logic signed [bws_pkg::AccW-1:0]     acc_r;
  logic signed [bws_pkg::AccW-1:0]     term;
  logic [bws_pkg::OffsetW:0]           grown;
  logic signed [bws_pkg::DiffW-1:0]    diff_l;
  logic signed [bws_pkg::DiffW-1:0]    diff_r;
  logic signed [bws_pkg::DiffW-1:0]    lim;

  function automatic logic signed [bws_pkg::SpeedW-1:0] clamp(
    input logic signed [bws_pkg::DiffW-1:0] v,
    input logic signed [bws_pkg::DiffW-1:0] l
  );
    logic signed [bws_pkg::DiffW-1:0] r;
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r[bws_pkg::SpeedW-1:0];
  endfunction

  assign out_ok  = !out_full || out_rd;
  assign adv     = !v2 || out_ok;
  assign mid_pop = adv && !mid_empty;
  assign out_wr  = v2 && out_ok;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      prod_next[i] = bws_pkg::ProductW'(mid_data.reading[i]) *
                     bws_pkg::ProductW'(bws_pkg::weight_mag(3'(i)));
    end
  end

  always_comb begin
    acc_l = bws_pkg::AccW'($signed({1'b0, cfg.base_speed, 8'd0}));
    acc_r = acc_l;
    term  = '0;
    for (int i = 0; i < N; i++) begin
      term  = bws_pkg::AccW'($signed({1'b0, prod[i]}));
      acc_l = bws_pkg::LeftNeg[i]  ? acc_l - term : acc_l + term;
      acc_r = bws_pkg::RightNeg[i] ? acc_r - term : acc_r + term;
    end
  end

  always_comb begin
    grown = {1'b0, offset} + (bws_pkg::OffsetW + 1)'(cfg.brake_step);
    if (brake1) begin
      offset_next = (grown > (bws_pkg::OffsetW + 1)'(bws_pkg::OffsetLimit)) ?
                    bws_pkg::OffsetW'(bws_pkg::OffsetLimit) :
                    grown[bws_pkg::OffsetW-1:0];
    end else begin
      offset_next = offset >> 1;
    end
  end

  always_comb begin
    lim    = bws_pkg::DiffW'($signed({1'b0, cfg.max_speed}));
    diff_l = bws_pkg::DiffW'(fl_l) - bws_pkg::DiffW'($signed({1'b0, offset}));
    diff_r = bws_pkg::DiffW'(fl_r) + bws_pkg::DiffW'($signed({1'b0, offset}));
    out_data.left_cmd     = clamp(diff_l, lim);
    out_data.right_cmd    = clamp(diff_r, lim);
    out_data.brake_active = brake2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      offset <= '0;
    end else if (adv) begin
      v1 <= !mid_empty;
      v2 <= v1;
      if (v1) begin
        offset <= offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= prod_next;
      brake1 <= mid_data.brake;
      fl_l   <= acc_l[bws_pkg::AccW-1:8];
      fl_r   <= acc_r[bws_pkg::AccW-1:8];
      brake2 <= brake1;
    end
  end

  `BWS_ASSERT_NEVER(a_offset_limit, clk, rst, offset > bws_pkg::OffsetW'(bws_pkg::OffsetLimit))
  `BWS_ASSERT(a_offset_grow, clk, rst, (adv && v1 && brake1) |=> (offset >= $past(offset)))
  `BWS_ASSERT(a_offset_decay, clk, rst, (adv && v1 && !brake1) |=> (offset <= $past(offset)))
  `BWS_ASSERT(a_stall_hold, clk, rst, (v2 && !adv) |=> (v2 && $stable(fl_l) && $stable(fl_r)))
  `BWS_ASSERT(a_clamp, clk, rst, out_wr |-> (out_data.left_cmd <= lim && out_data.left_cmd >= -lim))

endmodule

FILE: hdl/braitenberg_wheel_speed_top.sv
// Throughput: one frame per cycle while the result queue has room or is read;
// the two-stage back pipeline and the result queue set it.
// Each side stalls on its own through the front and result queues.
// Reset: synchronous, clears the queues, the brake offset and the registers
// to their defaults (thresholds 80 and 90, base 768, step 512, limit 1607).
module braitenberg_wheel_speed_top #(
  parameter int QUEUE_DEPTH = bws_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  bws_pkg::in_t              frame,
  output logic                      empty,
  input  logic                      pop,
  output bws_pkg::res_t             result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bws_pkg::AddrW-1:0] paddr,
  input  logic [bws_pkg::DataW-1:0] pwdata,
  output logic [bws_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  bws_pkg::cfg_t cfg;
  bws_pkg::mid_t front_item;
  bws_pkg::mid_t mid_data;
  bws_pkg::res_t out_data;
  logic          mid_empty;
  logic          mid_pop;
  logic          out_full;
  logic          out_wr;
  logic          out_rd;
  logic          in_wr;
  logic          cfg_wr;
  logic [bws_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[bws_pkg::AddrW-1:2];
  assign in_wr   = push && !full;
  assign out_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_threshold <= 12'd80;
      cfg.brake_threshold  <= 12'd90;
      cfg.base_speed       <= 11'd768;
      cfg.brake_step       <= 13'd512;
      cfg.max_speed        <= 11'd1607;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bws_pkg::RegSensorThr: cfg.sensor_threshold <= pwdata[11:0];
        bws_pkg::RegBrakeThr:  cfg.brake_threshold  <= pwdata[11:0];
        bws_pkg::RegBaseSpeed: cfg.base_speed       <= pwdata[10:0];
        bws_pkg::RegBrakeStep: cfg.brake_step       <= pwdata[12:0];
        bws_pkg::RegMaxSpeed:  cfg.max_speed        <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bws_pkg::RegSensorThr: prdata = bws_pkg::DataW'(cfg.sensor_threshold);
      bws_pkg::RegBrakeThr:  prdata = bws_pkg::DataW'(cfg.brake_threshold);
      bws_pkg::RegBaseSpeed: prdata = bws_pkg::DataW'(cfg.base_speed);
      bws_pkg::RegBrakeStep: prdata = bws_pkg::DataW'(cfg.brake_step);
      bws_pkg::RegMaxSpeed:  prdata = bws_pkg::DataW'(cfg.max_speed);
      default:               prdata = '0;
    endcase
  end

  bws_front u_front (
    .cfg   (cfg),
    .frame (frame),
    .item  (front_item)
  );

  bws_fifo #(
    .WIDTH ($bits(bws_pkg::mid_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_wr),
    .wr_data (front_item),
    .rd_en   (mid_pop),
    .rd_data (mid_data),
    .full    (full),
    .empty   (mid_empty)
  );

  bws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_data  (mid_data),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_rd    (out_rd),
    .out_wr    (out_wr),
    .out_data  (out_data)
  );

  bws_fifo #(
    .WIDTH ($bits(bws_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_data),
    .rd_en   (out_rd),
    .rd_data (result),
    .full    (out_full),
    .empty   (empty)
  );

endmodule

FILE: sim/tb_braitenberg_wheel_speed_top.sv
// Self-checking testbench for braitenberg_wheel_speed_top: frames in, wheel commands out.
// Predicts each command from its own copy of the registers and brake offset.
// Depends on bws_pkg and the RTL only.
module tb_braitenberg_wheel_speed_top;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 8;
  localparam int TrafficPhases = 7;
  localparam int PhaseFrames = 140;
  localparam logic [bws_pkg::RegIdxW-1:0] RegNone = 3'd5;

  typedef enum int {RxSteady, RxCoin, RxSparse, RxMostly} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  bws_pkg::in_t frame = '0;
  logic empty;
  logic pop = 1'b0;
  bws_pkg::res_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bws_pkg::AddrW-1:0] paddr = '0;
  logic [bws_pkg::DataW-1:0] pwdata = '0;
  logic [bws_pkg::DataW-1:0] prdata;
  logic pready;

  bws_pkg::cfg_t shadow_cfg;
  int brake_offset;
  int left_gain [8] = '{-2294, -3277, -1966, 1638, 1638, 1966, 3277, 2294};
  int right_gain [8] = '{2294, 3277, 1966, 1638, 1638, -1966, -3277, -2294};
  bws_pkg::res_t pending_cmds [$];
  bws_pkg::res_t want;

  int mismatches = 0;
  int frames_sent = 0;
  int cmds_checked = 0;
  int brake_frames = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int rx_left = 0;
  rx_mode_t rx_mode = RxSteady;

  braitenberg_wheel_speed_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .frame(frame),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic bws_pkg::res_t predict_wheel_cmd(input bws_pkg::in_t f);
    logic [bws_pkg::ReadingW-1:0] rd [8];
    longint acc_l, acc_r, lsp, rsp, grown;
    bit brk;
    bws_pkg::res_t cmd;
    for (int i = 0; i < 8; i++) rd[i] = f[(7 - i) * bws_pkg::ReadingW +: bws_pkg::ReadingW];
    acc_l = longint'(shadow_cfg.base_speed) * 256;
    acc_r = acc_l;
    for (int i = 0; i < 8; i++) begin
      if (rd[i] > shadow_cfg.sensor_threshold) begin
        acc_l += longint'(left_gain[i]) * longint'(rd[i]);
        acc_r += longint'(right_gain[i]) * longint'(rd[i]);
      end
    end
    brk = rd[0] > shadow_cfg.brake_threshold && rd[7] > shadow_cfg.brake_threshold;
    if (brk) begin
      grown = longint'(brake_offset) + longint'(shadow_cfg.brake_step);
      brake_offset = int'(clamp_mag(grown, bws_pkg::OffsetLimit));
      brake_frames++;
    end else begin
      brake_offset = brake_offset / 2;
    end
    lsp = clamp_mag((acc_l >>> 8) - brake_offset, longint'(shadow_cfg.max_speed));
    rsp = clamp_mag((acc_r >>> 8) + brake_offset, longint'(shadow_cfg.max_speed));
    cmd.left_cmd = lsp[bws_pkg::SpeedW-1:0];
    cmd.right_cmd = rsp[bws_pkg::SpeedW-1:0];
    cmd.brake_active = brk;
    return cmd;
  endfunction

  function automatic bws_pkg::in_t span_frame(input int lo, input int hi,
                                              input logic [11:0] v);
    bws_pkg::in_t f;
    f = '0;
    for (int i = lo; i <= hi; i++) f[(7 - i) * bws_pkg::ReadingW +: bws_pkg::ReadingW] = v;
    return f;
  endfunction

  function automatic bws_pkg::in_t front_frame(input logic [11:0] v);
    bws_pkg::in_t f;
    f = '0;
    f.prox_0 = v;
    f.prox_7 = v;
    return f;
  endfunction

  function automatic logic [11:0] rand_reading();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return shadow_cfg.sensor_threshold;
      3: return shadow_cfg.sensor_threshold + 12'd1;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic bws_pkg::in_t rand_frame(input bit braking);
    bws_pkg::in_t f;
    for (int i = 0; i < 8; i++) begin
      f[(7 - i) * bws_pkg::ReadingW +: bws_pkg::ReadingW] = rand_reading();
    end
    if (braking && shadow_cfg.brake_threshold != 12'hFFF) begin
      f.prox_0 = 12'($urandom_range(4095, shadow_cfg.brake_threshold + 1));
      f.prox_7 = 12'($urandom_range(4095, shadow_cfg.brake_threshold + 1));
    end
    return f;
  endfunction

  function automatic logic [31:0] pick_reg_value(input int width, input int hi);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'd0;
      1: v = hi;
      2: v = (32'd1 << width) - 1;
      default: v = $urandom_range(0, hi);
    endcase
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << width);
    return v;
  endfunction

  task automatic send_frame(input bws_pkg::in_t f);
    push <= 1'b1;
    frame <= f;
    do @(posedge clk); while (full);
    pending_cmds.push_back(predict_wheel_cmd(f));
    frames_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bws_pkg::RegIdxW-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bws_pkg::RegSensorThr: shadow_cfg.sensor_threshold = value[11:0];
      bws_pkg::RegBrakeThr:  shadow_cfg.brake_threshold = value[11:0];
      bws_pkg::RegBaseSpeed: shadow_cfg.base_speed = value[10:0];
      bws_pkg::RegBrakeStep: shadow_cfg.brake_step = value[12:0];
      bws_pkg::RegMaxSpeed:  shadow_cfg.max_speed = value[10:0];
      default: ;
    endcase
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random-length bursts, gapped unless no_gaps; runs of braking frames build up the offset.
  task automatic run_traffic(input int count, input bit no_gaps);
    int burst_left;
    int brake_left;
    burst_left = 0;
    brake_left = 0;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!no_gaps && $urandom_range(0, 2) != 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
      burst_left--;
      if (brake_left == 0 && $urandom_range(0, 9) == 0) brake_left = $urandom_range(1, 40);
      send_frame(rand_frame(brake_left != 0));
      if (brake_left != 0) brake_left--;
    end
  endtask

  task automatic test_defaults();
    send_frame(span_frame(0, 7, 12'd0));
    send_frame(span_frame(0, 7, 12'hFFF));
    send_frame(span_frame(0, 2, 12'hFFF));
    send_frame(span_frame(5, 7, 12'hFFF));
    wait_idle();
  endtask

  task automatic test_thresholds();
    send_frame(span_frame(0, 7, 12'd80));
    send_frame(span_frame(0, 7, 12'd81));
    send_frame(front_frame(12'd90));
    send_frame(front_frame(12'd91));
    wait_idle();
    write_reg(bws_pkg::RegSensorThr, 32'd4095);
    write_reg(bws_pkg::RegBrakeThr, 32'd4095);
    send_frame(span_frame(0, 7, 12'hFFF));
    wait_idle();
    write_reg(bws_pkg::RegSensorThr, 32'd0);
    write_reg(bws_pkg::RegBrakeThr, 32'd0);
    send_frame(span_frame(0, 7, 12'd1));
    wait_idle();
    write_reg(bws_pkg::RegSensorThr, 32'd80);
    write_reg(bws_pkg::RegBrakeThr, 32'd90);
  endtask

  task automatic test_offset_saturation();
    write_reg(bws_pkg::RegBrakeStep, 32'd4096);
    repeat (5) send_frame(front_frame(12'hFFF));
    send_frame(span_frame(0, 7, 12'd0));
    wait_idle();
    write_reg(bws_pkg::RegBrakeStep, 32'd8191);
    send_frame(front_frame(12'hFFF));
    repeat (3) send_frame(span_frame(0, 7, 12'd0));
    wait_idle();
    write_reg(bws_pkg::RegBrakeStep, 32'd0);
    send_frame(front_frame(12'hFFF));
    send_frame(span_frame(0, 7, 12'd0));
    wait_idle();
    write_reg(bws_pkg::RegBrakeStep, 32'd512);
  endtask

  task automatic test_speed_limits();
    write_reg(bws_pkg::RegMaxSpeed, 32'd0);
    send_frame(span_frame(0, 7, 12'hFFF));
    wait_idle();
    write_reg(bws_pkg::RegMaxSpeed, 32'd2047);
    write_reg(bws_pkg::RegBaseSpeed, 32'd2047);
    send_frame(span_frame(0, 7, 12'd0));
    wait_idle();
    write_reg(bws_pkg::RegBaseSpeed, 32'd0);
    send_frame(span_frame(0, 2, 12'hFFF));
    wait_idle();
    write_reg(bws_pkg::RegBaseSpeed, 32'd768);
    write_reg(bws_pkg::RegMaxSpeed, 32'd1607);
  endtask

  task automatic test_unknown_register();
    write_reg(RegNone, 32'hFFFF_FFFF);
    send_frame(span_frame(0, 7, 12'hFFF));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < TrafficPhases; p++) begin
      write_reg(bws_pkg::RegSensorThr, pick_reg_value(12, 4095));
      write_reg(bws_pkg::RegBrakeThr, pick_reg_value(12, 4095));
      write_reg(bws_pkg::RegBaseSpeed, pick_reg_value(11, 1607));
      write_reg(bws_pkg::RegBrakeStep, pick_reg_value(13, 4096));
      write_reg(bws_pkg::RegMaxSpeed, pick_reg_value(11, 1607));
      if ($urandom_range(0, 3) == 0) write_reg(RegNone, $urandom);
      run_traffic(PhaseFrames, 1'b0);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    run_traffic(60, 1'b1);
    wait_idle();
  endtask

  task automatic test_sender_pause();
    run_traffic(50, 1'b0);
    wait_idle();
    run_traffic(50, 1'b0);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
      rx_left <= 0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      pop <= 1'b0;
      hold_left <= HoldCycles;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(8, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RxSteady: pop <= 1'b1;
        RxCoin:   pop <= 1'($urandom_range(0, 1));
        RxSparse: pop <= ($urandom_range(0, 3) == 0);
        default:  pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction left %0d right %0d brake %0b", $time,
                 result.left_cmd, result.right_cmd, result.brake_active);
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (result.left_cmd !== want.left_cmd) begin
          mismatches++;
          $display("%0t: left_cmd expected %0d actual %0d", $time,
                   want.left_cmd, result.left_cmd);
        end
        if (result.right_cmd !== want.right_cmd) begin
          mismatches++;
          $display("%0t: right_cmd expected %0d actual %0d", $time,
                   want.right_cmd, result.right_cmd);
        end
        if (result.brake_active !== want.brake_active) begin
          mismatches++;
          $display("%0t: brake_active expected %0b actual %0b", $time,
                   want.brake_active, result.brake_active);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d transactions outstanding", cycle_count,
             pending_cmds.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    shadow_cfg.sensor_threshold = 12'd80;
    shadow_cfg.brake_threshold = 12'd90;
    shadow_cfg.base_speed = 11'd768;
    shadow_cfg.brake_step = 13'd512;
    shadow_cfg.max_speed = 11'd1607;
    brake_offset = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_thresholds();
    test_offset_saturation();
    test_speed_limits();
    test_unknown_register();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();
    wait_idle();
    $display("%0d frames sent, %0d wheel commands checked, %0d braking frames",
             frames_sent, cmds_checked, brake_frames);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
